>>> rtl/fqs_pkg.sv
// Package for the FIFO queue with search: operation codes, engine states,
// and the command and result transaction layouts.
// No dependencies.
package fqs_pkg;

	// Fixed port widths
	localparam int OUT_W  = 32;
	localparam int OCC_W  = 5;
	localparam int FUNC_W = 2;

	// Operation codes carried by func
	typedef enum logic [FUNC_W-1:0] {
		OP_ENQ  = 2'd0,
		OP_DEQ  = 2'd1,
		OP_SRCH = 2'd2,
		OP_CLR  = 2'd3
	} op_t;

	// Back-end engine states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HEAD,
		ST_SEARCH,
		ST_EMIT
	} state_t;

	// Command transaction from the front end to the engine
	typedef struct packed {
		op_t              op;
		logic [OUT_W-1:0] value;
	} cmd_t;

	// Result transaction from the engine to the output queue
	typedef struct packed {
		logic [OUT_W-1:0] result_value;
		logic             found;
		logic             underflow;
		logic             overflow;
		logic             is_empty;
		logic [OCC_W-1:0] occupancy;
		logic [OUT_W-1:0] head_word;
		logic [OUT_W-1:0] tail_word;
	} res_t;

endpackage

>>> rtl/fqs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fqs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/fqs_fifo.sv
// Two-entry queue that decouples neighboring stages; carries any packed payload.
// No dependencies.
module fqs_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_ptr_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// Store the incoming transaction
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

>>> rtl/fqs_engine.sv
// Back end of the queue: executes enqueue, dequeue, search and clear against
// the word RAM. Depends on fqs_pkg and fqs_ram.
module fqs_engine #(
	parameter int DEPTH     = 16,
	parameter int WORD_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_empty,
	input  fqs_pkg::cmd_t cmd_data,
	output logic          cmd_pop,
	input  logic          res_full,
	output logic          res_push,
	output fqs_pkg::res_t res_data
);

	localparam int SW = (WORD_BITS < fqs_pkg::OUT_W) ? WORD_BITS : fqs_pkg::OUT_W;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	fqs_pkg::state_t state_q, state_d;

	logic [AW-1:0]             head_q, tail_q, scan_ptr_q;
	logic [AW-1:0]             head_nx, tail_nx, scan_nx;
	logic [CW-1:0]             count_q, left_q;
	logic [SW-1:0]             head_word_q, tail_word_q, key_q;
	logic [fqs_pkg::OUT_W-1:0] res_val_q;
	logic                      found_q, under_q, over_q;
	logic                      start;
	logic                      is_full;
	logic [SW-1:0]             word;

	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [SW-1:0] ram_wdata, ram_rdata;

	assign head_nx = (head_q == LAST_IDX) ? '0 : head_q + AW'(1);
	assign tail_nx = (tail_q == LAST_IDX) ? '0 : tail_q + AW'(1);
	assign scan_nx = (scan_ptr_q == LAST_IDX) ? '0 : scan_ptr_q + AW'(1);
	assign is_full = (count_q == FULL_CNT);
	assign word    = cmd_data.value[SW-1:0];
	assign start   = (state_q == fqs_pkg::ST_IDLE) && !cmd_empty && !res_full;

	fqs_ram #(
		.WIDTH (SW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Next state, RAM access and handshakes
	always_comb begin
		state_d   = state_q;
		cmd_pop   = 1'b0;
		res_push  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = tail_q;
		ram_wdata = word;
		ram_raddr = scan_ptr_q;
		case (state_q)
			fqs_pkg::ST_IDLE: begin
				if (start) begin
					cmd_pop = 1'b1;
					state_d = fqs_pkg::ST_EMIT;
					case (cmd_data.op)
						fqs_pkg::OP_ENQ: begin
							ram_we = !is_full;
						end
						fqs_pkg::OP_DEQ: begin
							ram_raddr = head_nx;
							if (count_q > CW'(1)) begin
								state_d = fqs_pkg::ST_HEAD;
							end
						end
						fqs_pkg::OP_SRCH: begin
							ram_raddr = head_q;
							if (count_q != '0) begin
								state_d = fqs_pkg::ST_SEARCH;
							end
						end
						default: ;
					endcase
				end
			end
			fqs_pkg::ST_HEAD: begin
				state_d = fqs_pkg::ST_EMIT;
			end
			fqs_pkg::ST_SEARCH: begin
				if (left_q == '0) begin
					state_d = fqs_pkg::ST_EMIT;
				end
			end
			fqs_pkg::ST_EMIT: begin
				res_push = 1'b1;
				state_d  = fqs_pkg::ST_IDLE;
			end
			default: begin
				state_d = fqs_pkg::ST_IDLE;
			end
		endcase
	end

	// Hold state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fqs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Advance queue pointers, count and scan position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			scan_ptr_q <= '0;
			left_q     <= '0;
		end else if (start) begin
			case (cmd_data.op)
				fqs_pkg::OP_ENQ: begin
					if (!is_full) begin
						tail_q  <= tail_nx;
						count_q <= count_q + CW'(1);
					end
				end
				fqs_pkg::OP_DEQ: begin
					if (count_q != '0) begin
						head_q  <= head_nx;
						count_q <= count_q - CW'(1);
					end
				end
				fqs_pkg::OP_SRCH: begin
					scan_ptr_q <= head_nx;
					left_q     <= count_q - CW'(1);
				end
				default: begin
					head_q  <= '0;
					tail_q  <= '0;
					count_q <= '0;
				end
			endcase
		end else if (state_q == fqs_pkg::ST_SEARCH && left_q != '0) begin
			scan_ptr_q <= scan_nx;
			left_q     <= left_q - CW'(1);
		end
	end

	// Capture result values and cached end words
	always_ff @(posedge clk) begin
		if (start) begin
			res_val_q <= '0;
			found_q   <= 1'b0;
			under_q   <= 1'b0;
			over_q    <= 1'b0;
			key_q     <= word;
			case (cmd_data.op)
				fqs_pkg::OP_ENQ: begin
					over_q <= is_full;
					if (!is_full) begin
						tail_word_q <= word;
						if (count_q == '0) begin
							head_word_q <= word;
						end
					end
				end
				fqs_pkg::OP_DEQ: begin
					if (count_q == '0) begin
						under_q   <= 1'b1;
						res_val_q <= '1;
					end else begin
						res_val_q <= fqs_pkg::OUT_W'(head_word_q);
					end
				end
				default: ;
			endcase
		end else if (state_q == fqs_pkg::ST_HEAD) begin
			head_word_q <= ram_rdata;
		end else if (state_q == fqs_pkg::ST_SEARCH) begin
			if (ram_rdata == key_q) begin
				found_q <= 1'b1;
			end
		end
	end

	// Build the result transaction from the updated state
	always_comb begin
		res_data.result_value = res_val_q;
		res_data.found        = found_q;
		res_data.underflow    = under_q;
		res_data.overflow     = over_q;
		res_data.is_empty     = (count_q == '0);
		res_data.occupancy    = fqs_pkg::OCC_W'(count_q);
		res_data.head_word    = (count_q == '0) ? '0 : fqs_pkg::OUT_W'(head_word_q);
		res_data.tail_word    = (count_q == '0) ? '0 : fqs_pkg::OUT_W'(tail_word_q);
	end

endmodule

>>> rtl/fifo_queue_with_search.sv
// Top level of the FIFO queue with search: front-end command queue, engine
// and result queue. Depends on fqs_pkg, fqs_fifo and fqs_engine.
//
// Usage: push an operation (func: enqueue, dequeue, search, clear) with
// item_value while full is low; every operation yields exactly one result
// transaction, read while empty is low and taken with pop.
// The front end decodes func and parks up to two commands, so the caller
// can keep pushing while the engine works. Results wait in a two-entry
// queue; while the receiver stalls, the engine finishes its current
// operation, then holds, and push stalls once the command queue fills.
// Each operation passes through the engine states: enqueue and clear go
// straight to the emit state, dequeue passes through the head state when
// a new oldest word must be fetched from the word RAM, and search scans the
// occupied words, since the single RAM read port compares one stored word
// per cycle. The engine takes the next command only once back in idle.
// Reset empties the queue and both transaction queues; stored words are
// left as they are and are never read before being written.
module fifo_queue_with_search #(
	parameter int DEPTH     = 16,
	parameter int WORD_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  func,
	input  logic signed [31:0] item_value,
	output logic        empty,
	input  logic        pop,
	output logic signed [31:0] result_value,
	output logic        found,
	output logic        underflow,
	output logic        overflow,
	output logic        is_empty,
	output logic [4:0]  occupancy,
	output logic signed [31:0] head_word,
	output logic signed [31:0] tail_word
);

	fqs_pkg::cmd_t cmd_in, cmd_out;
	fqs_pkg::res_t res_in, res_out;
	logic          cmd_empty, cmd_pop;
	logic          res_full, res_push;

	// Classify the incoming transaction
	always_comb begin
		cmd_in.op    = fqs_pkg::op_t'(func);
		cmd_in.value = item_value;
	end

	fqs_fifo #(
		.WIDTH ($bits(fqs_pkg::cmd_t))
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cmd_in),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (cmd_out),
		.empty  (cmd_empty)
	);

	fqs_engine #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd_data  (cmd_out),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_data  (res_in)
	);

	fqs_fifo #(
		.WIDTH ($bits(fqs_pkg::res_t))
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_out),
		.empty  (empty)
	);

	// Unpack the oldest result onto the ports
	assign result_value = res_out.result_value;
	assign found        = res_out.found;
	assign underflow    = res_out.underflow;
	assign overflow     = res_out.overflow;
	assign is_empty     = res_out.is_empty;
	assign occupancy    = res_out.occupancy;
	assign head_word    = res_out.head_word;
	assign tail_word    = res_out.tail_word;

endmodule

>>> test/fqs_result_checker.sv
`timescale 1ns / 100ps
// Result checker for fifo_queue_with_search. It mirrors the queue contents,
// predicts every accepted operation and compares each result it sees.
// Depends on fqs_pkg.
module fqs_result_checker #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [1:0]  func,
	input  logic [31:0] item_value,
	input  logic        empty,
	input  logic        pop,
	input  logic [31:0] result_value,
	input  logic        found,
	input  logic        underflow,
	input  logic        overflow,
	input  logic        is_empty,
	input  logic [4:0]  occupancy,
	input  logic [31:0] head_word,
	input  logic [31:0] tail_word,
	output int          fail_count,
	output int          outstanding
);

	// Mirror of the queue: circular store, oldest slot, next write slot, count
	logic [31:0] words [DEPTH] = '{default: '0};
	int head_slot;
	int tail_slot;
	int word_count;

	// Results still owed by the block, oldest first
	fqs_pkg::res_t owed_results [$];

	// Apply one operation to the mirror and return the result it should give
	function automatic fqs_pkg::res_t apply_op(fqs_pkg::op_t op, logic [31:0] value);
		fqs_pkg::res_t r;
		int slot;
		r = '0;
		case (op)
			fqs_pkg::OP_ENQ: begin
				if (word_count >= DEPTH) begin
					r.overflow = 1'b1;
				end else begin
					words[tail_slot] = value;
					tail_slot = (tail_slot + 1) % DEPTH;
					word_count++;
				end
			end
			fqs_pkg::OP_DEQ: begin
				if (word_count == 0) begin
					r.underflow = 1'b1;
					r.result_value = '1;
				end else begin
					r.result_value = words[head_slot];
					head_slot = (head_slot + 1) % DEPTH;
					word_count--;
				end
			end
			fqs_pkg::OP_SRCH: begin
				// scan occupied entries only, oldest to newest
				slot = head_slot;
				for (int i = 0; i < word_count; i++) begin
					if (words[slot] == value)
						r.found = 1'b1;
					slot = (slot + 1) % DEPTH;
				end
			end
			default: begin
				// clear drops the count and indices, words stay put
				head_slot = 0;
				tail_slot = 0;
				word_count = 0;
			end
		endcase
		r.is_empty = (word_count == 0);
		r.occupancy = fqs_pkg::OCC_W'(word_count);
		if (word_count != 0) begin
			r.head_word = words[head_slot];
			r.tail_word = words[(tail_slot + DEPTH - 1) % DEPTH];
		end
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
		if (act_val !== exp_val) begin
			$error("%s: expected 0x%08h, got 0x%08h", name, exp_val, act_val);
			fail_count++;
		end
	endtask

	// Compare taken results first, then predict the newly accepted operation
	always @(posedge clk) begin
		fqs_pkg::res_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (owed_results.size() == 0) begin
					$error("result transaction with no operation outstanding");
					fail_count++;
				end else begin
					want = owed_results.pop_front();
					check_field("result_value", want.result_value, result_value);
					check_field("found", 32'(want.found), 32'(found));
					check_field("underflow", 32'(want.underflow), 32'(underflow));
					check_field("overflow", 32'(want.overflow), 32'(overflow));
					check_field("is_empty", 32'(want.is_empty), 32'(is_empty));
					check_field("occupancy", 32'(want.occupancy), 32'(occupancy));
					check_field("head_word", want.head_word, head_word);
					check_field("tail_word", want.tail_word, tail_word);
				end
			end
			if (push && !full)
				owed_results.push_back(apply_op(fqs_pkg::op_t'(func), item_value));
		end
		outstanding = owed_results.size();
	end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for fifo_queue_with_search: drives operation transactions and
// pops results under varying idle rates, then reports the verdict.
// Depends on fqs_pkg, fifo_queue_with_search and fqs_result_checker.
module tb_top;
	import fqs_pkg::*;

	localparam int DEPTH       = 16;
	localparam int PHASE_ITEMS = 284;
	localparam int HOLD_CYCLES = 80;

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	op_t                func;
	logic signed [31:0] item_value;
	logic               empty;
	logic               pop;
	logic signed [31:0] result_value;
	logic               found;
	logic               underflow;
	logic               overflow;
	logic               is_empty;
	logic [4:0]         occupancy;
	logic signed [31:0] head_word;
	logic signed [31:0] tail_word;

	int fail_count;
	int outstanding;

	// Idle rates in percent, hold-off request and its acknowledge
	int send_idle;
	int recv_idle;
	bit hold_req;
	bit hold_done;

	// Recently enqueued words, reused so that searches hit
	logic [31:0] recent [8] = '{default: '0};
	int recent_wr;

	fifo_queue_with_search #(.DEPTH(DEPTH), .WORD_BITS(32)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .func(func), .item_value(item_value),
		.empty(empty), .pop(pop),
		.result_value(result_value), .found(found), .underflow(underflow),
		.overflow(overflow), .is_empty(is_empty), .occupancy(occupancy),
		.head_word(head_word), .tail_word(tail_word)
	);

	fqs_result_checker #(.DEPTH(DEPTH)) i_checker (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .func(func), .item_value(item_value),
		.empty(empty), .pop(pop),
		.result_value(result_value), .found(found), .underflow(underflow),
		.overflow(overflow), .is_empty(is_empty), .occupancy(occupancy),
		.head_word(head_word), .tail_word(tail_word),
		.fail_count(fail_count), .outstanding(outstanding)
	);

	// 10 ns clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abort a hung run
	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// Receiver: random pop, with one long hold-off counted here
	initial begin
		pop = 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				pop <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// Offer one transaction, idling first at the sender's rate
	task automatic send_cmd(op_t op, logic [31:0] value);
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		func <= op;
		item_value <= value;
		if (op == OP_ENQ) begin
			recent[recent_wr] = value;
			recent_wr = (recent_wr + 1) % 8;
		end
		do @(posedge clk); while (full);
		@(negedge clk);
	endtask

	// Word mix: small values, full random, extremes, recent words
	function automatic logic [31:0] pick_value();
		int sel;
		sel = $urandom_range(9);
		if (sel <= 3)
			return 32'($urandom_range(7)) - 32'd4;
		if (sel <= 7)
			return $urandom;
		if (sel == 8) begin
			case ($urandom_range(3))
				0: return 32'h8000_0000;
				1: return 32'h7fff_ffff;
				2: return 32'hffff_ffff;
				default: return 32'h0000_0000;
			endcase
		end
		return recent[$urandom_range(7)];
	endfunction

	// Stimulus and verdict
	initial begin
		int mode;
		int r;
		arst_n = 1'b0;
		push = 1'b0;
		func = OP_ENQ;
		item_value = '0;
		send_idle = 11;
		recv_idle = 74;
		hold_req = 1'b0;
		recent_wr = 0;
		mode = 0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: underflow, empty search, extremes, hit and miss, clear, last word
		send_cmd(OP_DEQ, 32'h1234_5678);
		send_cmd(OP_SRCH, 32'h0000_0000);
		send_cmd(OP_ENQ, 32'h8000_0000);
		send_cmd(OP_ENQ, 32'h7fff_ffff);
		send_cmd(OP_ENQ, 32'hffff_ffff);
		send_cmd(OP_ENQ, 32'h0000_0000);
		send_cmd(OP_SRCH, 32'h7fff_ffff);
		send_cmd(OP_SRCH, 32'h0000_3039);
		send_cmd(OP_DEQ, 32'hffff_ffff);
		send_cmd(OP_CLR, 32'h5555_aaaa);
		send_cmd(OP_SRCH, 32'hffff_ffff);
		send_cmd(OP_ENQ, 32'h0000_0005);
		send_cmd(OP_DEQ, 32'h0000_0000);
		send_cmd(OP_DEQ, 32'h0000_0000);

		// Random: fill-heavy, drain-heavy and mixed stretches in three idle phases
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin send_idle = 11; recv_idle = 74; end
				1: begin send_idle = 74; recv_idle = 11; end
				default: begin send_idle = 0; recv_idle = 0; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (phase == 2 && n == 40)
					hold_req = 1'b1;
				if (n % 40 == 0)
					mode = $urandom_range(2);
				r = $urandom_range(99);
				if (r < (mode == 0 ? 70 : mode == 1 ? 20 : 40))
					send_cmd(OP_ENQ, pick_value());
				else if (r < (mode == 0 ? 82 : mode == 1 ? 78 : 75))
					send_cmd(OP_DEQ, $urandom);
				else if (r < (mode == 0 ? 99 : mode == 1 ? 98 : 97))
					send_cmd(OP_SRCH, $urandom_range(1) ? recent[$urandom_range(7)]
						: pick_value());
				else
					send_cmd(OP_CLR, $urandom);
			end
		end
		push <= 1'b0;

		// Drain, then allow stray results to show up
		wait (outstanding == 0);
		repeat (DEPTH + 8) @(negedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
